@@ src/stm_pkg.sv @@
// ----------------------------------------------------------------------------
// stm_pkg: shared definitions for the suffix trie matcher
// character codes, opcodes, status codes and the character folding function
// ----------------------------------------------------------------------------
package stm_pkg;

  // default configuration
  localparam int unsigned MAX_NODES_DEF      = 256;
  localparam int unsigned ALPHABET_SLOTS_DEF = 28;

  // character code width: '.' and 26 letters fit in five bits
  localparam int unsigned CODE_W = 5;

  // ascii bytes used by the folding function
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // add status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic              bad;
    logic [CODE_W-1:0] code;
  } char_code_t;

  // '.' -> 0, letters -> 1..26 (upper case folded), anything else is bad
  function automatic char_code_t char_code(input logic [7:0] b);
    char_code_t res;
    logic [7:0] folded;
    logic [7:0] offs;
    folded = b;
    res.bad = 1'b1;
    res.code = '0;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      folded = b + CASE_OFFSET;
    end
    offs = folded - CHAR_LOWER_A;
    if (b == CHAR_DOT) begin
      res.bad = 1'b0;
      res.code = '0;
    end else if (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_Z) begin
      res.bad = 1'b0;
      res.code = offs[CODE_W-1:0] + CODE_W'(1);
    end
    return res;
  endfunction

endpackage

@@ src/suffix_trie_match_core.sv @@
// ----------------------------------------------------------------------------
// suffix_trie_match_core: suffix trie add and match engine
// strings arrive one character per word, last character first; adds build
// the trie in a link memory, queries walk it and report a match
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The idle state, as it
// takes the word, reads the child link of the current node from the link
// memory; the exec state then uses the read data, writes back and updates
// the walk. Busy stays high in the exec state, so a new word is taken only
// once the last one is through it. The word that carries last_char gives
// one result, held on matched and status for exactly one cycle with done
// high, in the cycle after its exec state. The receiver cannot stall this
// strobe, so it must take the result in that cycle. After reset the block
// sweeps all MAX_NODES * ALPHABET_SLOTS link memory entries to zero, one
// entry a cycle, and keeps busy high throughout.
module suffix_trie_match_core
  import stm_pkg::*;
#(
  parameter int unsigned MAX_NODES      = MAX_NODES_DEF,
  parameter int unsigned ALPHABET_SLOTS = ALPHABET_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       opcode,
  input  logic [7:0] char_byte,
  input  logic       last_char,
  output logic       done,
  output logic       matched,
  output logic [1:0] status
);

  localparam int unsigned NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned NUSED_W = $clog2(MAX_NODES + 1);
  localparam int unsigned DEPTH   = MAX_NODES * ALPHABET_SLOTS;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  // each link entry carries the child node and that child's end mark; a
  // node has exactly one parent slot, so its mark lives there only. the
  // root is never marked: an add always steps to a child before marking
  typedef struct packed {
    logic              mark;
    logic [NODE_W-1:0] child;
  } entry_t;

  state_t state, state_next;

  // link memory
  entry_t            link_mem [DEPTH];
  entry_t            rd_entry;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  // clearing sweep
  logic [ADDR_W-1:0] clr_cnt;

  // walk state
  logic [NUSED_W-1:0] nodes_used, nodes_used_next;
  logic [NODE_W-1:0]  cur_node, cur_node_next;
  logic               cur_mark, cur_mark_next;
  logic               decided, decided_next;
  logic               decided_val, decided_val_next;
  logic [1:0]         add_error, add_error_next;

  // word held for the exec state
  logic              item_op;
  logic              item_bad;
  logic              item_fin;
  logic [ADDR_W-1:0] item_slot;

  logic       done_next;
  logic       matched_next;
  logic [1:0] status_next;

  char_code_t in_code;
  logic       accept;
  logic       step_ok;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign in_code = char_code(char_byte);

  // read the slot of the current node; a bad character reads slot zero of
  // the row and the read data is ignored
  assign mem_re    = accept;
  assign mem_raddr = ADDR_W'(cur_node) * ADDR_W'(ALPHABET_SLOTS)
                   + (in_code.bad ? ADDR_W'(0) : ADDR_W'(in_code.code));

  // the write of one word lands at the end of its exec state and the next
  // read can only come from the idle state after it, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_entry <= link_mem[mem_raddr];
    end
  end

  always_comb begin
    state_next       = state;
    nodes_used_next  = nodes_used;
    cur_node_next    = cur_node;
    cur_mark_next    = cur_mark;
    decided_next     = decided;
    decided_val_next = decided_val;
    add_error_next   = add_error;
    mem_we           = 1'b0;
    mem_waddr        = item_slot;
    mem_wdata        = '0;
    done_next        = 1'b0;
    matched_next     = 1'b0;
    status_next      = ST_OK;
    step_ok          = 1'b0;

    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_IDLE;
        if (item_op == OP_ADD) begin
          // add: walk or create a link, stop on the first error
          if (add_error == ST_OK) begin
            if (item_bad) begin
              add_error_next = ST_BAD_CHAR;
            end else if (rd_entry.child == '0) begin
              if (nodes_used == NUSED_W'(MAX_NODES)) begin
                add_error_next = ST_FULL;
              end else begin
                cur_node_next   = nodes_used[NODE_W-1:0];
                cur_mark_next   = 1'b0;
                nodes_used_next = nodes_used + NUSED_W'(1);
                mem_we          = 1'b1;
                step_ok         = 1'b1;
              end
            end else begin
              cur_node_next = rd_entry.child;
              cur_mark_next = rd_entry.mark;
              step_ok       = 1'b1;
            end
          end
          // final word marks the node reached through this slot
          if (item_fin && step_ok) begin
            mem_we = 1'b1;
          end
          mem_wdata.mark  = item_fin && step_ok;
          mem_wdata.child = cur_node_next;
          status_next     = add_error_next;
        end else begin
          // query: decide on a marked node, a bad character or a dead end
          if (!decided) begin
            if (cur_mark) begin
              decided_next     = 1'b1;
              decided_val_next = 1'b1;
            end else if (item_bad || rd_entry.child == '0) begin
              decided_next     = 1'b1;
              decided_val_next = 1'b0;
            end else begin
              cur_node_next = rd_entry.child;
              cur_mark_next = rd_entry.mark;
            end
          end
          matched_next = decided_next ? decided_val_next : cur_mark_next;
        end

        // end of string: give the result and return to the root
        if (item_fin) begin
          done_next        = 1'b1;
          cur_node_next    = '0;
          cur_mark_next    = 1'b0;
          decided_next     = 1'b0;
          decided_val_next = 1'b0;
          add_error_next   = ST_OK;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      nodes_used  <= NUSED_W'(1);
      cur_node    <= '0;
      cur_mark    <= 1'b0;
      decided     <= 1'b0;
      decided_val <= 1'b0;
      add_error   <= ST_OK;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      nodes_used  <= nodes_used_next;
      cur_node    <= cur_node_next;
      cur_mark    <= cur_mark_next;
      decided     <= decided_next;
      decided_val <= decided_val_next;
      add_error   <= add_error_next;
      done        <= done_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op   <= opcode;
      item_bad  <= in_code.bad;
      item_fin  <= last_char;
      item_slot <= mem_raddr;
    end
    matched <= matched_next;
    status  <= status_next;
  end

endmodule
